// ===== sv/median_ema_sample_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the median and moving average sample filter.
// Both macros expect a clock named clock and a synchronous reset named reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_EMA_SAMPLE_FILTER_CORE_MACROS_SVH
`define MEDIAN_EMA_SAMPLE_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MESF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mesf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MESF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mesf assertion failed");

`endif

// ===== sv/mesf_pkg.sv =====
// ----------------------------------------------------------------------------
// mesf_pkg
// Types and constants shared by the median and moving average filter.
// ----------------------------------------------------------------------------
package mesf_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 16;
   localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int ALPHA_BITS  = 16;
   localparam int LEN_BITS    = 8;
   localparam int CSR_BITS    = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd22938;
   localparam logic [LEN_BITS-1:0]   LEN_RESET   = 8'd20;

   localparam logic [CSR_BITS-1:0] CSR_ALPHA         = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_SERIES_LENGTH = 2'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   restart;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] filtered;
      logic [LEN_BITS-1:0]    series_index;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] median;
      logic                   restart;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [ALPHA_BITS-1:0] alpha;
      logic [LEN_BITS-1:0]   series_length;
   } cfg_type;

endpackage

// ===== sv/mesf_front.sv =====
// ----------------------------------------------------------------------------
// mesf_front
// Takes samples into a sorted cell row and hands each group median onward.
// ----------------------------------------------------------------------------
module mesf_front
   import mesf_pkg::*;
#(
   parameter int GROUP_SIZE = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type queue_status,
   output logic             push,
   output entry_type        push_entry
);

   localparam int FILL_BITS = $clog2(GROUP_SIZE + 1);
   localparam int MID       = GROUP_SIZE / 2;

   logic [SAMPLE_BITS-1:0] cells_ff [GROUP_SIZE];
   logic [SAMPLE_BITS-1:0] cells_in [GROUP_SIZE];
   logic [FILL_BITS-1:0]   fill_ff, fill_in, fill_eff;
   logic                   pending_ff, pending_in;
   logic [GROUP_SIZE-1:0]  greater;
   logic                   accept, complete;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;
   assign fill_eff  = req_data.restart ? '0 : fill_ff;
   assign complete  = (fill_eff == FILL_BITS'(GROUP_SIZE - 1));

   // Cells past the fill level act as larger than any sample.
   always_comb begin
      for (int i = 0; i < GROUP_SIZE; i++) begin
         greater[i] = (FILL_BITS'(i) >= fill_eff) || (cells_ff[i] > req_data.sample);
      end
      for (int i = 0; i < GROUP_SIZE; i++) begin
         if (!greater[i]) begin
            cells_in[i] = cells_ff[i];
         end else if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
            cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
         end else begin
            cells_in[i] = req_data.sample;
         end
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      pending_in = pending_ff;
      if (accept) begin
         fill_in    = complete ? '0 : fill_eff + 1'b1;
         pending_in = complete ? 1'b0 : (pending_ff | req_data.restart);
      end
   end

   assign push              = accept && complete;
   assign push_entry.median  = cells_in[MID];
   assign push_entry.restart = pending_ff | req_data.restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cells_ff <= cells_in;
      end
   end

endmodule

// ===== sv/mesf_queue.sv =====
// ----------------------------------------------------------------------------
// mesf_queue
// Short queue of group medians between the sorter and the averaging unit.
// ----------------------------------------------------------------------------
module mesf_queue
   import mesf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type queue_status
);

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign head_entry         = slots_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/mesf_back.sv =====
// ----------------------------------------------------------------------------
// mesf_back
// Moving average sequencer: updates the average from each median and
// drives the result register.
// ----------------------------------------------------------------------------
`include "median_ema_sample_filter_core_macros.svh"

module mesf_back
   import mesf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type queue_status,
   input  entry_type        head_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_MULT_NEW = 5'b00010,
      ST_MULT_OLD = 5'b00100,
      ST_UPDATE   = 5'b01000,
      ST_FINISH   = 5'b10000
   } back_state_type;

   localparam int NEW_BITS = ALPHA_BITS + SAMPLE_BITS;
   localparam int OLD_BITS = ALPHA_BITS + 1 + AVG_BITS;
   localparam int SUM_BITS = OLD_BITS + 1;
   localparam logic [ALPHA_BITS:0] FRAC_ONE  = (ALPHA_BITS + 1)'(1) << ALPHA_BITS;
   localparam logic [AVG_BITS-1:0] HALF_FRAC = AVG_BITS'(1) << (FRAC_BITS - 1);

   back_state_type         state_ff, state_in;
   logic [SAMPLE_BITS-1:0] median_ff, median_in;
   logic [NEW_BITS-1:0]    prod_new_ff, prod_new_in;
   logic [OLD_BITS-1:0]    prod_old_ff, prod_old_in;
   logic [AVG_BITS-1:0]    average_ff, average_in;
   logic                   avg_valid_ff, avg_valid_in;
   logic [LEN_BITS-1:0]    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [ALPHA_BITS:0]    one_minus_alpha;
   logic [SUM_BITS-1:0]    sum;
   logic [AVG_BITS-1:0]    rounded;
   logic [LEN_BITS-1:0]    series_len, next_index;
   logic                   out_free, is_last, load;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign one_minus_alpha = FRAC_ONE - {1'b0, cfg.alpha};
   assign sum             = SUM_BITS'({prod_new_ff, FRAC_BITS'(0)}) + SUM_BITS'(prod_old_ff)
                            + SUM_BITS'(HALF_FRAC);
   assign rounded         = average_ff + HALF_FRAC;
   assign series_len      = (cfg.series_length == '0) ? LEN_BITS'(1) : cfg.series_length;
   assign next_index      = count_ff + 1'b1;
   assign is_last         = (next_index == series_len);
   assign pop             = (state_ff == ST_IDLE) && !queue_status.empty;
   assign load            = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in     = state_ff;
      median_in    = median_ff;
      prod_new_in  = prod_new_ff;
      prod_old_in  = prod_old_ff;
      average_in   = average_ff;
      avg_valid_in = avg_valid_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               median_in = head_entry.median;
               if (head_entry.restart) begin
                  avg_valid_in = 1'b0;
                  count_in     = '0;
               end
               state_in = ST_MULT_NEW;
            end
         end
         ST_MULT_NEW: begin
            prod_new_in = cfg.alpha * median_ff;
            state_in    = ST_MULT_OLD;
         end
         ST_MULT_OLD: begin
            prod_old_in = one_minus_alpha * average_ff;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (avg_valid_ff) begin
               average_in = sum[FRAC_BITS +: AVG_BITS];
            end else begin
               average_in = {median_ff, FRAC_BITS'(0)};
            end
            avg_valid_in = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.filtered      = rounded[FRAC_BITS +: SAMPLE_BITS];
               rsp_data_in.series_index  = next_index;
               rsp_data_in.last          = is_last;
               avg_valid_in              = !is_last;
               count_in                  = is_last ? '0 : next_index;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_valid_ff <= avg_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff   <= median_in;
      prod_new_ff <= prod_new_in;
      prod_old_ff <= prod_old_in;
      average_ff  <= average_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MESF_ASSERT_NEXT(a_result_from_finish, !rsp_valid_ff, !rsp_valid_ff || $past(load))
   `MESF_ASSERT_NEXT(a_load_shows_result, load, rsp_valid_ff && state_ff == ST_IDLE)
   `MESF_ASSERT_NEXT(a_series_continues, load && !is_last, count_ff == $past(next_index))
   `MESF_ASSERT_SAME(a_average_ready, state_ff == ST_FINISH, avg_valid_ff)

endmodule

// ===== sv/median_ema_sample_filter_core.sv =====
// ----------------------------------------------------------------------------
// median_ema_sample_filter_core
// Groups samples, takes each group median and smooths the medians with an
// exponential moving average.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  sample, restart
//   rsp      out        rsp_valid/rsp_stall  filtered, series_index, last
//   csr      in         csr_write_enable     csr_index, csr_wdata
//
// A sample is taken every cycle while the median queue has room. Each group
// median passes through the averaging sequencer steps in order (pop, two
// multiplies, update, output). The sustained rate is one sample per cycle
// for groups of five or more without result stalls, less for shorter groups.
// Reset is synchronous and needs no clearing pass. A stalled result holds the
// output register; the sorter keeps taking samples until the queue fills.
// ----------------------------------------------------------------------------
module median_ema_sample_filter_core
   import mesf_pkg::*;
#(
   parameter int GROUP_SIZE = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write_enable,
   input  logic [CSR_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type queue_status;
   entry_type        push_entry, head_entry;
   logic             push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ALPHA:         cfg_in.alpha         = csr_wdata[ALPHA_BITS-1:0];
            CSR_SERIES_LENGTH: cfg_in.series_length = csr_wdata[LEN_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha         <= ALPHA_RESET;
         cfg_ff.series_length <= LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mesf_front #(
      .GROUP_SIZE(GROUP_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_status(queue_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   mesf_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .pop         (pop),
      .head_entry  (head_entry),
      .queue_status(queue_status)
   );

   mesf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_status(queue_status),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
